// File: design/bus_voltage_filter_fault_monitor_top_defines.svh
// Assertion macros for the bus voltage filter and fault monitor.
`ifndef BUS_VOLTAGE_FILTER_FAULT_MONITOR_TOP_DEFINES_SVH
`define BUS_VOLTAGE_FILTER_FAULT_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BVF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BVF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bvf_pkg.sv
// Shared types and constants for the bus voltage filter and fault monitor.
package bvf_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int SAMPLE_W       = 16;
    localparam int WIN_W          = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int Q_DEPTH        = 2;
    localparam int TRIM_DROP      = 2;
    localparam int MIN_WINDOW     = 3;

    localparam logic [SAMPLE_W-1:0] INVALID_CODE = 16'hFFFF;

    localparam logic [15:0]      RST_OVER    = 16'hFFFF;
    localparam logic [15:0]      RST_UNDER   = 16'h0000;
    localparam logic [WIN_W-1:0] RST_WINDOW  = 6'd8;
    localparam logic [15:0]      RST_CHECKS  = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVER    = 3'd0,
        CFG_UNDER   = 3'd1,
        CFG_WINDOW  = 3'd2,
        CFG_TRIMMED = 3'd3,
        CFG_CHECKS  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_OVER  = 2'd1,
        FAULT_UNDER = 2'd2
    } t_fault;

    // Work items handed from front to back.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PUSH  = 2'd1,
        OP_TRIM  = 2'd2,
        OP_SKIP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_WRITE,
        BK_SUM,
        BK_DIV,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [15:0] over;
        logic [15:0] under;
        logic        trimmed;
        logic [15:0] checks;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic emit;
    } t_back_stat;

endpackage

// File: design/bvf_queue.sv
// Small request queue between the front and back parts.
module bvf_queue import bvf_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    input  logic         i_rd,
    output logic [W-1:0] o_rdata,
    output logic         o_valid,
    output logic         o_full
);
    localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    logic [W-1:0]      r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: design/bvf_front.sv
// Front part: accepts requests, classifies them and collects trimmed bursts.
module bvf_front import bvf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  logic                                        i_cmd,
    input  logic [SAMPLE_W-1:0]                         i_sample,
    output logic                                        o_in_stall,
    input  t_cfg                                        i_cfg,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]             i_len,
    input  logic                                        i_flush,
    input  logic                                        i_q_full,
    output logic                                        o_q_wr,
    output t_op                                         o_q_op,
    output logic [SAMPLE_W+$clog2(MAX_WINDOW+1)-1:0]    o_q_data
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    logic [CNT_W-1:0]    r_bcnt, n_bcnt;
    logic [SUM_W-1:0]    r_bsum, n_bsum;
    logic [SAMPLE_W-1:0] r_bmin, n_bmin, r_bmax, n_bmax;
    logic                w_acc;
    logic                w_first;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [16:0]         w_mid_sum;

    assign o_in_stall = i_q_full;
    assign w_acc      = i_in_valid && !i_q_full;
    assign w_first    = (r_bcnt == '0);
    assign w_cnt_inc  = r_bcnt + 1'b1;
    assign w_mid_sum  = {1'b0, i_cfg.over} + {1'b0, i_cfg.under};

    always_comb begin
        n_bcnt   = r_bcnt;
        n_bsum   = r_bsum;
        n_bmin   = r_bmin;
        n_bmax   = r_bmax;
        o_q_wr   = 1'b0;
        o_q_op   = OP_SKIP;
        o_q_data = SUM_W'(i_sample);
        if (w_acc) begin
            if (i_cmd) begin
                o_q_wr   = 1'b1;
                o_q_op   = OP_CLEAR;
                o_q_data = SUM_W'(w_mid_sum[16:1]);
                n_bcnt   = '0;
            end else if (!i_cfg.trimmed) begin
                o_q_wr = 1'b1;
                o_q_op = (i_sample == INVALID_CODE) ? OP_SKIP : OP_PUSH;
            end else if (i_sample != INVALID_CODE) begin
                n_bmin = (w_first || i_sample < r_bmin) ? i_sample : r_bmin;
                n_bmax = (w_first || i_sample > r_bmax) ? i_sample : r_bmax;
                n_bsum = (w_first ? '0 : r_bsum) + SUM_W'(i_sample);
                if (w_cnt_inc == i_len) begin
                    o_q_wr   = 1'b1;
                    o_q_op   = OP_TRIM;
                    o_q_data = n_bsum - SUM_W'(n_bmax) - SUM_W'(n_bmin);
                    n_bcnt   = '0;
                end else begin
                    n_bcnt = w_cnt_inc;
                end
            end
        end
        if (i_flush) begin
            n_bcnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else begin
            r_bcnt <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bsum <= n_bsum;
        r_bmin <= n_bmin;
        r_bmax <= n_bmax;
    end

endmodule

// File: design/bvf_back.sv
// Back part: ring memory, sum sweep, shared serial divider and fault check.
module bvf_back import bvf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_cfg                                        i_cfg,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]             i_len,
    input  logic                                        i_q_valid,
    input  t_op                                         i_q_op,
    input  logic [SAMPLE_W+$clog2(MAX_WINDOW+1)-1:0]    i_q_data,
    output logic                                        o_q_rd,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [1:0]                                  o_fault,
    output logic [SAMPLE_W-1:0]                         o_average,
    output logic [SAMPLE_W-1:0]                         o_latest,
    output t_back_stat                                  o_stat
);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    t_back_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_ring_vld;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                w_mem_we, w_mem_re;
    logic [IDX_W-1:0]    w_mem_waddr, w_mem_raddr;
    logic [SAMPLE_W-1:0] w_mem_wdata;
    logic [SAMPLE_W-1:0] w_rd_val;

    logic [SAMPLE_W-1:0] r_entry, n_entry;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rd_pend, n_rd_pend;
    logic [SUM_W-1:0]    r_acc, n_acc;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]    r_div, n_div;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_trim, n_trim;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [SAMPLE_W-1:0] r_latest, n_latest;
    logic [15:0]         r_su_cnt, n_su_cnt;
    logic                r_su_done, n_su_done;
    logic                r_out_valid, n_out_valid;
    t_fault              r_fault, n_fault;
    logic [SAMPLE_W-1:0] r_out_avg, n_out_avg;
    logic [SAMPLE_W-1:0] r_out_latest, n_out_latest;

    logic [CNT_W:0]      w_rem_sh;
    logic [CNT_W:0]      w_rem_sub;
    logic                w_qbit;
    logic [IDX_W-1:0]    w_slot;

    assign w_rd_val   = r_rd_vld ? r_rd_data : '0;
    assign w_rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_div};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_div});
    // A stale write index (window shrunk since) restarts at slot zero.
    assign w_slot     = ({1'b0, r_wr_idx} >= (IDX_W+1)'(i_len)) ? '0 : r_wr_idx;

    assign o_out_valid = r_out_valid;
    assign o_fault     = r_fault;
    assign o_average   = r_out_avg;
    assign o_latest    = r_out_latest;
    assign o_stat.busy = (r_state != BK_IDLE);
    assign o_stat.emit = (r_state == BK_EMIT);

    always_comb begin
        n_state      = r_state;
        n_entry      = r_entry;
        n_wr_idx     = r_wr_idx;
        n_cnt        = r_cnt;
        n_rd_pend    = 1'b0;
        n_acc        = r_acc;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_step       = r_step;
        n_trim       = r_trim;
        n_avg        = r_avg;
        n_latest     = r_latest;
        n_su_cnt     = r_su_cnt;
        n_su_done    = r_su_done;
        n_out_valid  = r_out_valid && i_out_stall;
        n_fault      = r_fault;
        n_out_avg    = r_out_avg;
        n_out_latest = r_out_latest;
        o_q_rd       = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_cnt[IDX_W-1:0];
        w_mem_wdata  = r_entry;
        w_mem_re     = 1'b0;
        w_mem_raddr  = r_cnt[IDX_W-1:0];

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_rd = 1'b1;
                    unique case (i_q_op)
                        OP_CLEAR: begin
                            n_entry  = i_q_data[SAMPLE_W-1:0];
                            n_avg    = i_q_data[SAMPLE_W-1:0];
                            n_latest = i_q_data[SAMPLE_W-1:0];
                            n_wr_idx = '0;
                            n_cnt    = '0;
                            n_state  = BK_CLEAR;
                        end
                        OP_PUSH: begin
                            n_entry = i_q_data[SAMPLE_W-1:0];
                            n_state = BK_WRITE;
                        end
                        OP_TRIM: begin
                            n_quo   = i_q_data;
                            n_rem   = '0;
                            n_div   = i_len - CNT_W'(TRIM_DROP);
                            n_step  = '0;
                            n_trim  = 1'b1;
                            n_state = BK_DIV;
                        end
                        OP_SKIP: begin
                            n_state = BK_EMIT;
                        end
                        default: n_state = BK_IDLE;
                    endcase
                end
            end
            BK_CLEAR: begin
                w_mem_we = 1'b1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == i_len - 1'b1) begin
                    n_state = BK_IDLE;
                end
            end
            BK_WRITE: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_slot;
                n_latest    = r_entry;
                n_wr_idx    = ({1'b0, w_slot} < (IDX_W+1)'(i_len - 1'b1))
                              ? w_slot + 1'b1 : '0;
                n_cnt       = '0;
                n_acc       = '0;
                n_state     = BK_SUM;
            end
            BK_SUM: begin
                if (r_cnt < i_len) begin
                    w_mem_re  = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_acc = r_acc + SUM_W'(w_rd_val);
                end
                if (r_cnt == i_len && !r_rd_pend) begin
                    n_quo   = r_acc;
                    n_rem   = '0;
                    n_div   = i_len;
                    n_step  = '0;
                    n_trim  = 1'b0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                // Restoring divide, one quotient bit per cycle.
                n_rem  = w_qbit ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
                n_quo  = {r_quo[SUM_W-2:0], w_qbit};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    if (r_trim) begin
                        n_entry = n_quo[SAMPLE_W-1:0];
                        n_state = BK_WRITE;
                    end else begin
                        n_avg   = n_quo[SAMPLE_W-1:0];
                        n_state = BK_EMIT;
                    end
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (!r_su_done && r_su_cnt >= i_cfg.checks) begin
                        n_su_done = 1'b1;
                    end else if (!r_su_done) begin
                        n_su_cnt = r_su_cnt + 1'b1;
                    end
                    priority if (r_avg > i_cfg.over) begin
                        n_fault = FAULT_OVER;
                    end else if (r_avg < i_cfg.under && n_su_done) begin
                        n_fault = FAULT_UNDER;
                    end else begin
                        n_fault = FAULT_NONE;
                    end
                    n_out_valid  = 1'b1;
                    n_out_avg    = r_avg;
                    n_out_latest = r_latest;
                    n_state      = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wr_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_avg       <= '0;
            r_latest    <= '0;
            r_su_cnt    <= '0;
            r_su_done   <= 1'b0;
            r_out_valid <= 1'b0;
            r_ring_vld  <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_pend   <= n_rd_pend;
            r_avg       <= n_avg;
            r_latest    <= n_latest;
            r_su_cnt    <= n_su_cnt;
            r_su_done   <= n_su_done;
            r_out_valid <= n_out_valid;
            if (w_mem_we) begin
                r_ring_vld[w_mem_waddr] <= 1'b1;
            end
            if (w_mem_re) begin
                r_rd_vld <= r_ring_vld[w_mem_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry      <= n_entry;
        r_cnt        <= n_cnt;
        r_acc        <= n_acc;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_trim       <= n_trim;
        r_fault      <= n_fault;
        r_out_avg    <= n_out_avg;
        r_out_latest <= n_out_latest;
    end

    // Ring storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_ring[w_mem_raddr];
        end
    end

endmodule

// File: design/bus_voltage_filter_fault_monitor_top.sv
// Top level of the bus voltage moving-average filter and fault monitor.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | request   | i_in_valid / o_in_stall   | i_cmd, i_sample
//  out     | result    | o_out_valid / i_out_stall | o_fault, o_average, o_latest
//  cfg     | write     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A direct sample passes through the back part as pop, ring write, ring sweep,
// divide (one quotient bit a cycle) and fault check. A request that completes a
// trimmed burst first runs the divider once more before its ring write; other
// trimmed samples stay in the front part. A clear writes every window slot.
// Reset clears the ring's valid bits at once; a two-entry queue lets the front
// keep accepting while the back works, and the output register holds a stall.

`include "bus_voltage_filter_fault_monitor_top_defines.svh"

module bus_voltage_filter_fault_monitor_top import bvf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_fault,
    output logic [SAMPLE_W-1:0]   o_average,
    output logic [SAMPLE_W-1:0]   o_latest,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int QW    = SUM_W + 2;

    logic [15:0]      r_over, r_under, r_checks;
    logic [WIN_W-1:0] r_window;
    logic             r_trimmed;
    t_cfg             w_cfg;
    logic [CNT_W-1:0] w_len;
    logic             w_flush;

    logic             w_q_wr, w_q_rd, w_q_valid, w_q_full;
    t_op              w_fr_op;
    logic [SUM_W-1:0] w_fr_data;
    logic [QW-1:0]    w_q_rdata;
    t_back_stat       w_stat;

    assign w_cfg.over    = r_over;
    assign w_cfg.under   = r_under;
    assign w_cfg.trimmed = r_trimmed;
    assign w_cfg.checks  = r_checks;

    // Effective window: register value clamped to [3, MAX_WINDOW].
    assign w_len = (r_window < WIN_W'(MIN_WINDOW)) ? CNT_W'(MIN_WINDOW) :
                   (32'(r_window) > MAX_WINDOW)    ? CNT_W'(MAX_WINDOW) :
                                                     CNT_W'(r_window);

    // Changing window or mode drops a partial trimmed burst.
    assign w_flush = i_cfg_we && (i_cfg_idx == CFG_WINDOW || i_cfg_idx == CFG_TRIMMED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over    <= RST_OVER;
            r_under   <= RST_UNDER;
            r_window  <= RST_WINDOW;
            r_trimmed <= 1'b0;
            r_checks  <= RST_CHECKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OVER:    r_over    <= i_cfg_data;
                CFG_UNDER:   r_under   <= i_cfg_data;
                CFG_WINDOW:  r_window  <= i_cfg_data[WIN_W-1:0];
                CFG_TRIMMED: r_trimmed <= i_cfg_data[0];
                CFG_CHECKS:  r_checks  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    bvf_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sample   (i_sample),
        .o_in_stall (o_in_stall),
        .i_cfg      (w_cfg),
        .i_len      (w_len),
        .i_flush    (w_flush),
        .i_q_full   (w_q_full),
        .o_q_wr     (w_q_wr),
        .o_q_op     (w_fr_op),
        .o_q_data   (w_fr_data)
    );

    bvf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata ({w_fr_op, w_fr_data}),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_rdata),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    bvf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_len       (w_len),
        .i_q_valid   (w_q_valid),
        .i_q_op      (t_op'(w_q_rdata[QW-1:SUM_W])),
        .i_q_data    (w_q_rdata[SUM_W-1:0]),
        .o_q_rd      (w_q_rd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fault     (o_fault),
        .o_average   (o_average),
        .o_latest    (o_latest),
        .o_stat      (w_stat)
    );

    // Queue never overflows or underflows, and a result only appears
    // right after the back part's fault-check step.
    `BVF_ASSERT_IMP(a_q_no_overflow, w_q_full, !w_q_wr, "queue written while full")
    `BVF_ASSERT_IMP(a_q_no_underflow, w_q_rd, w_q_valid, "queue read while empty")
    `BVF_ASSERT_IMP(a_result_after_emit, $rose(o_out_valid), $past(w_stat.emit), "result without fault check")
    `BVF_ASSERT_NXT(a_emit_clears_busy, w_stat.emit && !(o_out_valid && i_out_stall), !w_stat.busy, "back stuck after emit")

endmodule
